// File: rtl/bhp_pkg.sv
// Shared types, constants and elaboration-time helpers for the high-pass coefficient generator.
`default_nettype none

package bhp_pkg;

    localparam int COEF_WIDTH_DEF  = 32;
    localparam int OCTAVE_SPAN_DEF = 7;

    localparam int CTRL_W = 16;
    localparam int BASE_W = 18;
    localparam logic [BASE_W-1:0] BASE_RESET = 18'd15218;

    localparam int MANT_W = 32;
    localparam int TAYLOR_TERMS = 8;
    localparam int ALPHA_STEPS = 31;
    localparam int ALPHA_DIV_W = 24;
    localparam int COEF_DIV_W = 36;
    localparam int LANES = 4;

    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [29:0] HALF_Q30 = 30'h2000_0000;

    typedef struct packed {
        logic [2:0]        octave;
        logic [CTRL_W-1:0] res;
    } t_exp_side;

    typedef struct packed {
        logic [1:0][30:0]  x;
        logic [1:0]        quad;
        logic [CTRL_W-1:0] res;
    } t_ty_side;

    typedef struct packed {
        logic        neg;
        logic [31:0] cs;
    } t_al_side;

    typedef struct packed {
        logic sat;
        logic zero;
        logic neg;
    } t_coef_flag;

    typedef t_coef_flag [LANES-1:0] t_coef_flags;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_w;
        rem   = v;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_w) begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Factor 2^(2^-step) in Q1.31, each one the truncated root of the one before.
    function automatic logic [31:0] exp_factor(input int step);
        logic [63:0] r;
        r = 64'd1 << 32;
        for (int k = 1; k <= CTRL_W; k++) begin
            if (k <= step) begin
                r = isqrt64(r << 31);
            end
        end
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/bhp_exp_cell.sv
// One cell of the exponent chain: multiplies the mantissa by one root-of-two factor when its fraction bit is set.
`default_nettype none

module bhp_exp_cell #(
    parameter int STEP   = 1,
    parameter int SIDE_W = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [bhp_pkg::CTRL_W-1:0]  i_frac,
    input  wire logic [bhp_pkg::MANT_W-1:0]  i_mant,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    output logic [bhp_pkg::CTRL_W-1:0]       o_frac,
    output logic [bhp_pkg::MANT_W-1:0]       o_mant,
    output logic [SIDE_W-1:0]                o_side
);

    localparam logic [31:0] FACTOR = bhp_pkg::exp_factor(STEP);
    localparam int BIT_IDX = bhp_pkg::CTRL_W - STEP;

    logic                          r_valid;
    logic [bhp_pkg::CTRL_W-1:0]    r_frac;
    logic [bhp_pkg::MANT_W-1:0]    r_mant;
    logic [SIDE_W-1:0]             r_side;
    logic [63:0]                   prod;
    logic [bhp_pkg::MANT_W-1:0]    n_mant;

    always_comb begin
        prod   = 64'(i_mant) * 64'(FACTOR) + (64'd1 << 30);
        n_mant = i_frac[BIT_IDX] ? prod[62:31] : i_mant;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frac <= i_frac;
            r_mant <= n_mant;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_frac  = r_frac;
    assign o_mant  = r_mant;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: rtl/bhp_taylor_cell.sv
// One Horner term of the sine series, run on the sine and cosine lanes side by side.
`default_nettype none

module bhp_taylor_cell #(
    parameter int TERM   = 8,
    parameter int SIDE_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [1:0][31:0]   i_x2,
    input  wire logic [1:0][30:0]   i_s,
    input  wire logic [SIDE_W-1:0]  i_side,
    output logic                    o_valid,
    output logic [1:0][31:0]        o_x2,
    output logic [1:0][30:0]        o_s,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int DIVISOR = (2 * TERM) * (2 * TERM + 1);
    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / DIVISOR;
    localparam logic [29:0] RECIP = 30'(RECIP_FULL);
    localparam logic [8:0] DIV_C = 9'(DIVISOR);

    logic                r_a_valid, r_b_valid, r_c_valid;
    logic [1:0][31:0]    r_a_v, r_b_v;
    logic [1:0][29:0]    r_b_q0;
    logic [1:0][31:0]    r_a_x2, r_b_x2, r_c_x2;
    logic [1:0][30:0]    r_c_s;
    logic [SIDE_W-1:0]   r_a_side, r_b_side, r_c_side;

    logic [1:0][62:0]    a_prod;
    logic [1:0][31:0]    n_a_v;
    logic [1:0][61:0]    b_prod;
    logic [1:0][29:0]    n_b_q0;
    logic [1:0][38:0]    c_q0d;
    logic [1:0][31:0]    c_rem;
    logic [1:0][30:0]    c_q;
    logic [1:0][30:0]    n_c_s;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            a_prod[l] = 63'(i_x2[l]) * 63'(i_s[l]) + 63'(bhp_pkg::HALF_Q30);
            n_a_v[l]  = a_prod[l][61:30];
            b_prod[l] = 62'(r_a_v[l]) * 62'(RECIP);
            n_b_q0[l] = b_prod[l][61:32];
            // The reciprocal estimate is at most one short; one compare fixes it.
            c_q0d[l]  = 39'(r_b_q0[l]) * 39'(DIV_C);
            c_rem[l]  = r_b_v[l] - c_q0d[l][31:0];
            c_q[l]    = 31'(r_b_q0[l]) + 31'(c_rem[l] >= 32'(DIV_C));
            n_c_s[l]  = bhp_pkg::ONE_Q30 - c_q[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_v    <= n_a_v;
            r_a_x2   <= i_x2;
            r_a_side <= i_side;
            r_b_q0   <= n_b_q0;
            r_b_v    <= r_a_v;
            r_b_x2   <= r_a_x2;
            r_b_side <= r_a_side;
            r_c_s    <= n_c_s;
            r_c_x2   <= r_b_x2;
            r_c_side <= r_b_side;
        end
    end

    assign o_valid = r_c_valid;
    assign o_x2    = r_c_x2;
    assign o_s     = r_c_s;
    assign o_side  = r_c_side;

endmodule

`default_nettype wire

// File: rtl/bhp_div_cell.sv
// One restoring-division step, one quotient bit per lane.
`default_nettype none

module bhp_div_cell #(
    parameter int LANES  = 1,
    parameter int W      = 24,
    parameter int QW     = 31,
    parameter int SIDE_W = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [LANES-1:0][W-1:0]    i_rem,
    input  wire logic [LANES-1:0][W-1:0]    i_div,
    input  wire logic [LANES-1:0][QW-1:0]   i_nq,
    input  wire logic [SIDE_W-1:0]          i_side,
    output logic                            o_valid,
    output logic [LANES-1:0][W-1:0]         o_rem,
    output logic [LANES-1:0][W-1:0]         o_div,
    output logic [LANES-1:0][QW-1:0]        o_nq,
    output logic [SIDE_W-1:0]               o_side
);

    logic                        r_valid;
    logic [LANES-1:0][W-1:0]     r_rem, r_div;
    logic [LANES-1:0][QW-1:0]    r_nq;
    logic [SIDE_W-1:0]           r_side;

    logic [LANES-1:0][W:0]       sh_val;
    logic [LANES-1:0][W:0]       diff;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0][W-1:0]     n_rem;
    logic [LANES-1:0][QW-1:0]    n_nq;

    // The dividend leaves the top of nq one bit a step while quotient bits enter below.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sh_val[l] = {i_rem[l], i_nq[l][QW-1]};
            diff[l]   = sh_val[l] - {1'b0, i_div[l]};
            ge[l]     = sh_val[l] >= {1'b0, i_div[l]};
            n_rem[l]  = ge[l] ? diff[l][W-1:0] : sh_val[l][W-1:0];
            n_nq[l]   = {i_nq[l][QW-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_nq   <= n_nq;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_nq    = r_nq;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: rtl/biquad_highpass_coef_gen.sv
// Top level: fully pipelined high-pass biquad coefficient generator.
`default_nettype none

// Each item (cutoff and resonance, Q0.16) yields one set of high-pass coefficients in
// signed Q3.(COEF_WIDTH-4); gain equals the second feedforward term. A new item is taken
// every cycle unless the skid entry is full. It holds 16 exponent, eight sine-series
// Horner, 31 alpha and COEF_WIDTH-1 coefficient division cells, with register stages
// between. An output register with one skid entry keeps the input open while a result
// waits; the pipeline stalls only when both are full. The user must write the base
// frequency register through its own channel only while the block is idle (not enforced).
module biquad_highpass_coef_gen #(
    parameter int COEF_WIDTH  = bhp_pkg::COEF_WIDTH_DEF,
    parameter int OCTAVE_SPAN = bhp_pkg::OCTAVE_SPAN_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [bhp_pkg::CTRL_W-1:0]  i_cutoff_control,
    input  wire logic [bhp_pkg::CTRL_W-1:0]  i_resonance_control,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [COEF_WIDTH-1:0]            o_gain_coef,
    output logic [COEF_WIDTH-1:0]            o_feedforward_one,
    output logic [COEF_WIDTH-1:0]            o_feedforward_two,
    output logic [COEF_WIDTH-1:0]            o_feedback_one,
    output logic [COEF_WIDTH-1:0]            o_feedback_two,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bhp_pkg::BASE_W-1:0]  i_base_frequency
);

    localparam int EXP_STEPS  = bhp_pkg::CTRL_W;
    localparam int TERMS      = bhp_pkg::TAYLOR_TERMS;
    localparam int AL_STEPS   = bhp_pkg::ALPHA_STEPS;
    localparam int CF_STEPS   = COEF_WIDTH - 1;
    localparam int LANES      = bhp_pkg::LANES;
    localparam int AW         = bhp_pkg::ALPHA_DIV_W;
    localparam int CW         = bhp_pkg::COEF_DIV_W;
    localparam int EX_SIDE_W  = $bits(bhp_pkg::t_exp_side);
    localparam int TY_SIDE_W  = $bits(bhp_pkg::t_ty_side);
    localparam int AL_SIDE_W  = $bits(bhp_pkg::t_al_side);
    localparam int CF_SIDE_W  = $bits(bhp_pkg::t_coef_flags);
    localparam logic [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam logic [31:0] ONE32 = 32'h4000_0000;

    logic en;
    logic [bhp_pkg::BASE_W-1:0] r_base;

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= bhp_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_base_frequency;
        end
    end
    assign o_cfg_ready = 1'b1;

    // Input stage: split cutoff*span into octave and fraction.
    logic [18:0] cut_span;
    logic        r_s0_valid;
    logic [2:0]  r_s0_oct;
    logic [15:0] r_s0_frac;
    logic [15:0] r_s0_res;

    assign cut_span = 19'(i_cutoff_control) * 19'(OCTAVE_SPAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_oct  <= cut_span[18:16];
            r_s0_frac <= cut_span[15:0];
            r_s0_res  <= i_resonance_control;
        end
    end

    // Exponent chain.
    logic [EXP_STEPS:0]                           ex_valid;
    logic [EXP_STEPS:0][bhp_pkg::CTRL_W-1:0]      ex_frac;
    logic [EXP_STEPS:0][bhp_pkg::MANT_W-1:0]      ex_mant;
    bhp_pkg::t_exp_side [EXP_STEPS:0]             ex_side;

    assign ex_valid[0]       = r_s0_valid;
    assign ex_frac[0]        = r_s0_frac;
    assign ex_mant[0]        = 32'h8000_0000;
    assign ex_side[0].octave = r_s0_oct;
    assign ex_side[0].res    = r_s0_res;

    for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
        bhp_exp_cell #(
            .STEP   (g + 1),
            .SIDE_W (EX_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ex_valid[g]),
            .i_frac  (ex_frac[g]),
            .i_mant  (ex_mant[g]),
            .i_side  (ex_side[g]),
            .o_valid (ex_valid[g+1]),
            .o_frac  (ex_frac[g+1]),
            .o_mant  (ex_mant[g+1]),
            .o_side  (ex_side[g+1])
        );
    end

    // Angle: base times mantissa, then shift by the octave and round to Q30 pi units.
    logic        r_s1_valid;
    logic [49:0] r_s1_prod;
    logic [2:0]  r_s1_oct;
    logic [15:0] r_s1_res;

    logic [56:0] ang_sh;
    logic [56:0] ang_rnd;
    logic [30:0] ang;
    logic [29:0] u_sin;
    logic [1:0][29:0] n_s2_u;
    logic        r_s2_valid;
    logic [1:0][29:0] r_s2_u;
    logic [1:0]  r_s2_quad;
    logic [15:0] r_s2_res;

    always_comb begin
        ang_sh    = 57'(r_s1_prod) << r_s1_oct;
        ang_rnd   = ang_sh + 57'd16777216;
        ang       = ang_rnd[55:25];
        u_sin     = {1'b0, ang[28:0]};
        n_s2_u[0] = u_sin;
        n_s2_u[1] = bhp_pkg::HALF_Q30 - u_sin;
    end

    // Scale by pi and square.
    logic [1:0][61:0] xp;
    logic [1:0][30:0] n_s3_x;
    logic        r_s3_valid;
    logic [1:0][30:0] r_s3_x;
    logic [1:0]  r_s3_quad;
    logic [15:0] r_s3_res;

    logic [1:0][61:0] x2p;
    logic [1:0][31:0] n_s4_x2;
    logic        r_s4_valid;
    logic [1:0][31:0] r_s4_x2;
    logic [1:0][30:0] r_s4_x;
    logic [1:0]  r_s4_quad;
    logic [15:0] r_s4_res;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            xp[l]      = 62'(r_s2_u[l]) * 62'(bhp_pkg::PI_Q30) + 62'(bhp_pkg::HALF_Q30);
            n_s3_x[l]  = xp[l][60:30];
            x2p[l]     = 62'(r_s3_x[l]) * 62'(r_s3_x[l]) + 62'(bhp_pkg::HALF_Q30);
            n_s4_x2[l] = x2p[l][61:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= ex_valid[EXP_STEPS];
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_prod <= 50'(r_base) * 50'(ex_mant[EXP_STEPS]);
            r_s1_oct  <= ex_side[EXP_STEPS].octave;
            r_s1_res  <= ex_side[EXP_STEPS].res;
            r_s2_u    <= n_s2_u;
            r_s2_quad <= ang[30:29];
            r_s2_res  <= r_s1_res;
            r_s3_x    <= n_s3_x;
            r_s3_quad <= r_s2_quad;
            r_s3_res  <= r_s2_res;
            r_s4_x2   <= n_s4_x2;
            r_s4_x    <= r_s3_x;
            r_s4_quad <= r_s3_quad;
            r_s4_res  <= r_s3_res;
        end
    end

    // Horner chain; lane 0 holds the sine angle, lane 1 the complementary one.
    logic [TERMS:0]                ty_valid;
    logic [TERMS:0][1:0][31:0]     ty_x2;
    logic [TERMS:0][1:0][30:0]     ty_s;
    bhp_pkg::t_ty_side [TERMS:0]   ty_side;

    assign ty_valid[0]     = r_s4_valid;
    assign ty_x2[0]        = r_s4_x2;
    assign ty_s[0]         = {bhp_pkg::ONE_Q30, bhp_pkg::ONE_Q30};
    assign ty_side[0].x    = r_s4_x;
    assign ty_side[0].quad = r_s4_quad;
    assign ty_side[0].res  = r_s4_res;

    for (genvar g = 0; g < TERMS; g++) begin : g_taylor
        bhp_taylor_cell #(
            .TERM   (TERMS - g),
            .SIDE_W (TY_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ty_valid[g]),
            .i_x2    (ty_x2[g]),
            .i_s     (ty_s[g]),
            .i_side  (ty_side[g]),
            .o_valid (ty_valid[g+1]),
            .o_x2    (ty_x2[g+1]),
            .o_s     (ty_s[g+1]),
            .o_side  (ty_side[g+1])
        );
    end

    // Last multiply by x, clamp to one, then apply the quadrant.
    logic [1:0][61:0] sp;
    logic [1:0][31:0] sf;
    logic [1:0][30:0] n_s5_sc;
    logic        r_s5_valid;
    logic [1:0][30:0] r_s5_sc;
    logic [1:0]  r_s5_quad;
    logic [15:0] r_s5_res;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sp[l]      = 62'(ty_side[TERMS].x[l]) * 62'(ty_s[TERMS][l])
                         + 62'(bhp_pkg::HALF_Q30);
            sf[l]      = sp[l][61:30];
            n_s5_sc[l] = (sf[l] > ONE32) ? bhp_pkg::ONE_Q30 : sf[l][30:0];
        end
    end

    logic [30:0] sn_mag;
    logic [31:0] cs_pos;
    logic [31:0] n_s6_cs;
    logic        r_s6_valid;
    logic [30:0] r_s6_mag;
    logic        r_s6_neg;
    logic [31:0] r_s6_cs;
    logic [AW-1:0] r_s6_dalpha;

    always_comb begin
        sn_mag  = r_s5_quad[0] ? r_s5_sc[1] : r_s5_sc[0];
        cs_pos  = r_s5_quad[0] ? {1'b0, r_s5_sc[0]} : {1'b0, r_s5_sc[1]};
        // Cosine is negative in the second and third quadrants.
        n_s6_cs = (r_s5_quad[0] ^ r_s5_quad[1]) ? (32'd0 - cs_pos) : cs_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else if (en) begin
            r_s5_valid <= ty_valid[TERMS];
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_sc     <= n_s5_sc;
            r_s5_quad   <= ty_side[TERMS].quad;
            r_s5_res    <= ty_side[TERMS].res;
            r_s6_mag    <= sn_mag;
            r_s6_neg    <= r_s5_quad[1];
            r_s6_cs     <= n_s6_cs;
            r_s6_dalpha <= AW'(r_s5_res) * AW'(200) + AW'(65536);
        end
    end

    // Alpha division: |sin| * 65536 over 200*res + 65536.
    logic [AL_STEPS:0]                      al_valid;
    logic [AL_STEPS:0][0:0][AW-1:0]         al_rem;
    logic [AL_STEPS:0][0:0][AW-1:0]         al_div;
    logic [AL_STEPS:0][0:0][AL_STEPS-1:0]   al_nq;
    bhp_pkg::t_al_side [AL_STEPS:0]         al_side;

    assign al_valid[0]     = r_s6_valid;
    assign al_rem[0][0]    = AW'(r_s6_mag[30:15]);
    assign al_div[0][0]    = r_s6_dalpha;
    assign al_nq[0][0]     = {r_s6_mag[14:0], 16'd0};
    assign al_side[0].neg  = r_s6_neg;
    assign al_side[0].cs   = r_s6_cs;

    for (genvar g = 0; g < AL_STEPS; g++) begin : g_alpha
        bhp_div_cell #(
            .LANES  (1),
            .W      (AW),
            .QW     (AL_STEPS),
            .SIDE_W (AL_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (al_valid[g]),
            .i_rem   (al_rem[g]),
            .i_div   (al_div[g]),
            .i_nq    (al_nq[g]),
            .i_side  (al_side[g]),
            .o_valid (al_valid[g+1]),
            .o_rem   (al_rem[g+1]),
            .o_div   (al_div[g+1]),
            .o_nq    (al_nq[g+1]),
            .o_side  (al_side[g+1])
        );
    end

    // Numerators and denominators; lanes are ff2, ff1, fb1, fb2.
    logic [31:0] alpha_pos;
    logic [31:0] alpha_v;
    logic [31:0] den;
    logic [31:0] cs_abs;
    logic [31:0] cs_v;
    logic [LANES-1:0][31:0] n_s7_a;
    logic [LANES-1:0][32:0] n_s7_d;
    logic [LANES-1:0]       n_s7_neg;
    logic                   r_s7_valid;
    logic [LANES-1:0][31:0] r_s7_a;
    logic [LANES-1:0][32:0] r_s7_d;
    logic [LANES-1:0]       r_s7_neg;

    always_comb begin
        cs_v        = al_side[AL_STEPS].cs;
        alpha_pos   = {1'b0, al_nq[AL_STEPS][0]};
        alpha_v     = al_side[AL_STEPS].neg ? (32'd0 - alpha_pos) : alpha_pos;
        den         = ONE32 + alpha_v;
        cs_abs      = cs_v[31] ? (32'd0 - cs_v) : cs_v;
        n_s7_a[0]   = ONE32 + cs_v;
        n_s7_d[0]   = {den, 1'b0};
        n_s7_neg[0] = 1'b0;
        n_s7_a[1]   = ONE32 + cs_v;
        n_s7_d[1]   = {1'b0, den};
        n_s7_neg[1] = 1'b1;
        n_s7_a[2]   = {cs_abs[30:0], 1'b0};
        n_s7_d[2]   = {1'b0, den};
        n_s7_neg[2] = !cs_v[31] && (cs_v != 32'd0);
        n_s7_a[3]   = ONE32 - alpha_v;
        n_s7_d[3]   = {1'b0, den};
        n_s7_neg[3] = 1'b0;
    end

    logic [LANES-1:0][CW-1:0] n_s8_dd;
    bhp_pkg::t_coef_flags     n_s8_flags;
    logic                     r_s8_valid;
    logic [LANES-1:0][CW-1:0] r_s8_a;
    logic [LANES-1:0][CW-1:0] r_s8_dd;
    bhp_pkg::t_coef_flags     r_s8_flags;

    // The divider runs against eight times the denominator, so an integer part of
    // eight or more shows up as the saturation case before the chain.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s8_dd[l]         = {r_s7_d[l], 3'b000};
            n_s8_flags[l].zero = (r_s7_d[l] == 33'd0) && (r_s7_a[l] == 32'd0);
            n_s8_flags[l].sat  = (r_s7_d[l] == 33'd0) ? (r_s7_a[l] != 32'd0)
                                                      : (CW'(r_s7_a[l]) >= n_s8_dd[l]);
            n_s8_flags[l].neg  = r_s7_neg[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
            r_s8_valid <= 1'b0;
        end else if (en) begin
            r_s7_valid <= al_valid[AL_STEPS];
            r_s8_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_a   <= n_s7_a;
            r_s7_d   <= n_s7_d;
            r_s7_neg <= n_s7_neg;
            for (int l = 0; l < LANES; l++) begin
                r_s8_a[l] <= CW'(r_s7_a[l]);
            end
            r_s8_dd    <= n_s8_dd;
            r_s8_flags <= n_s8_flags;
        end
    end

    // Coefficient division chain.
    logic [CF_STEPS:0]                           cf_valid;
    logic [CF_STEPS:0][LANES-1:0][CW-1:0]        cf_rem;
    logic [CF_STEPS:0][LANES-1:0][CW-1:0]        cf_div;
    logic [CF_STEPS:0][LANES-1:0][CF_STEPS-1:0]  cf_nq;
    bhp_pkg::t_coef_flags [CF_STEPS:0]           cf_side;

    assign cf_valid[0] = r_s8_valid;
    assign cf_rem[0]   = r_s8_a;
    assign cf_div[0]   = r_s8_dd;
    assign cf_nq[0]    = '0;
    assign cf_side[0]  = r_s8_flags;

    for (genvar g = 0; g < CF_STEPS; g++) begin : g_coef
        bhp_div_cell #(
            .LANES  (LANES),
            .W      (CW),
            .QW     (CF_STEPS),
            .SIDE_W (CF_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cf_valid[g]),
            .i_rem   (cf_rem[g]),
            .i_div   (cf_div[g]),
            .i_nq    (cf_nq[g]),
            .i_side  (cf_side[g]),
            .o_valid (cf_valid[g+1]),
            .o_rem   (cf_rem[g+1]),
            .o_div   (cf_div[g+1]),
            .o_nq    (cf_nq[g+1]),
            .o_side  (cf_side[g+1])
        );
    end

    // Sign and saturation.
    logic [LANES-1:0][COEF_WIDTH-1:0] coef_mag;
    logic [LANES-1:0][COEF_WIDTH-1:0] n_coef;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            coef_mag[l] = {1'b0, cf_nq[CF_STEPS][l]};
            if (cf_side[CF_STEPS][l].zero) begin
                n_coef[l] = '0;
            end else if (cf_side[CF_STEPS][l].sat) begin
                n_coef[l] = cf_side[CF_STEPS][l].neg ? COEF_MIN : COEF_MAX;
            end else if (cf_side[CF_STEPS][l].neg) begin
                n_coef[l] = '0 - coef_mag[l];
            end else begin
                n_coef[l] = coef_mag[l];
            end
        end
    end

    // Output register and one skid entry; the pipeline halts only when the skid is full.
    logic                             r_out_valid;
    logic [LANES-1:0][COEF_WIDTH-1:0] r_out_data;
    logic                             r_skid_full;
    logic [LANES-1:0][COEF_WIDTH-1:0] r_skid_data;
    logic                             out_free;

    assign en       = !r_skid_full;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (en) begin
            if (out_free) begin
                r_out_valid <= cf_valid[CF_STEPS];
            end else if (cf_valid[CF_STEPS]) begin
                r_skid_full <= 1'b1;
            end
        end else if (i_ready) begin
            r_skid_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (out_free) begin
                r_out_data <= n_coef;
            end else begin
                r_skid_data <= n_coef;
            end
        end else if (i_ready) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_ready           = en;
    assign o_valid           = r_out_valid;
    assign o_gain_coef       = r_out_data[0];
    assign o_feedforward_two = r_out_data[0];
    assign o_feedforward_one = r_out_data[1];
    assign o_feedback_one    = r_out_data[2];
    assign o_feedback_two    = r_out_data[3];

endmodule

`default_nettype wire
